FILE: src/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// Shared constants and control/status types for the integer-to-decimal core.
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned DIG_IDX_W  = 4;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] RADIX      = 4'd10;

  // ceil(2^35 / 10): floor(x * RECIP_TEN / 2^35) equals x / 10 for every 32-bit x.
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;

  typedef struct packed {
    logic load;        // capture a new value and split off its sign
    logic divide;      // peel one digit off the magnitude
    logic emit_sign;   // load the minus sign into the output register
    logic emit_digit;  // load the next digit into the output register
  } itda_cmd_t;

  typedef struct packed {
    logic quot_zero;   // the quotient of the current divide step is zero
    logic sign_pend;   // a minus sign still has to go out
    logic last_digit;  // the next digit to go out is the least significant
  } itda_status_t;

endpackage

FILE: src/int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_core
// Signed 32-bit integer to decimal ASCII text, one character per output item.
// ----------------------------------------------------------------------------
// Each input item is a signed 32-bit value; the core returns its decimal text
// most significant character first, with a leading '-' for negative values,
// no leading zeros, and a single '0' for zero. The final character of each
// number has out_tlast set. The most negative value gives "-2147483648".
// Operation: after an item is accepted, one divide-by-ten step runs per cycle
// until the quotient reaches zero (one step per digit of an N-digit number,
// N from 1 to 10), then characters leave at one per cycle unless out_tready
// stalls them, through the output register (N or N+1 characters). The item
// rate is set by the single shared divide-by-ten unit followed by the single
// output register. The next item is taken as soon as the last character has
// been loaded, even while that character still waits on out_tready.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_core
  import itda_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input channel.
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [VALUE_W-1:0]  in_tdata,   // [31:0] value
  // Result channel.
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [CHAR_W-1:0]   out_tdata,  // [7:0] ascii_char
  output logic                out_tlast   // is_last
);

  itda_cmd_t    cmd;
  itda_status_t status;

  // The controller owns the handshakes and the output valid flag.
  itda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the magnitude, the digit buffer and the output character.
  itda_datapath u_datapath (
    .clk        (clk),
    .value      (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .ascii_char (out_tdata),
    .is_last    (out_tlast)
  );

  // Every character that goes out is a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == CHAR_MINUS) ||
                   ((out_tdata >= CHAR_ZERO) && (out_tdata <= CHAR_NINE)))
    else $error("output character is neither a sign nor a digit");

  // A minus sign is always followed by at least one digit.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata == CHAR_MINUS)) |-> !out_tlast)
    else $error("minus sign flagged as the last character");

  // A stalled character stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled output item changed");

  // Two items are never accepted back to back.
  a_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

endmodule

FILE: src/itda_datapath.sv
// ----------------------------------------------------------------------------
// itda_datapath
// Magnitude register, divide-by-ten step, digit buffer and output register.
// ----------------------------------------------------------------------------
module itda_datapath
  import itda_pkg::*;
(
  input  logic                clk,
  input  logic [VALUE_W-1:0]  value,
  input  itda_cmd_t           cmd,
  output itda_status_t        status,
  output logic [CHAR_W-1:0]   ascii_char,
  output logic                is_last
);

  logic [VALUE_W-1:0]   mag_r, mag_nxt;
  logic                 sign_pend_r, sign_pend_nxt;
  logic [DIG_IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [DIG_IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [DIGIT_W-1:0]   digits_r [MAX_DIGITS];
  logic [CHAR_W-1:0]    char_r, char_nxt;
  logic                 last_r, last_nxt;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   quot_x10;
  logic [VALUE_W-1:0]   rem_full;
  logic [DIGIT_W-1:0]   rem;

  // Reciprocal multiply gives the quotient; the remainder follows from a shift-add.
  assign prod     = (2*VALUE_W)'(mag_r) * (2*VALUE_W)'(RECIP_TEN);
  assign quot     = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem_full = mag_r - quot_x10;
  assign rem      = rem_full[DIGIT_W-1:0];

  always_comb begin
    mag_nxt       = mag_r;
    sign_pend_nxt = sign_pend_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    if (cmd.load) begin
      sign_pend_nxt = value[VALUE_W-1];
      mag_nxt       = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
      wr_idx_nxt    = '0;
    end
    if (cmd.divide) begin
      mag_nxt    = quot;
      rd_idx_nxt = wr_idx_r;
      wr_idx_nxt = wr_idx_r + DIG_IDX_W'(1);
    end
    if (cmd.emit_sign) begin
      char_nxt      = CHAR_MINUS;
      last_nxt      = 1'b0;
      sign_pend_nxt = 1'b0;
    end
    if (cmd.emit_digit) begin
      char_nxt   = CHAR_ZERO + CHAR_W'(digits_r[rd_idx_r]);
      last_nxt   = (rd_idx_r == '0);
      rd_idx_nxt = rd_idx_r - DIG_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    sign_pend_r <= sign_pend_nxt;
    wr_idx_r    <= wr_idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    char_r      <= char_nxt;
    last_r      <= last_nxt;
    if (cmd.divide) begin
      digits_r[wr_idx_r] <= rem;
    end
  end

  assign status.quot_zero  = (quot == '0);
  assign status.sign_pend  = sign_pend_r;
  assign status.last_digit = (rd_idx_r == '0);

  assign ascii_char = char_r;
  assign is_last    = last_r;

endmodule

FILE: src/itda_ctrl.sv
// ----------------------------------------------------------------------------
// itda_ctrl
// Sequencer: accept, divide until the quotient is zero, then emit characters.
// ----------------------------------------------------------------------------
module itda_ctrl
  import itda_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  itda_status_t status,
  output itda_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.divide = 1'b1;
        if (status.quot_zero) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (status.sign_pend) begin
            cmd.emit_sign = 1'b1;
          end else begin
            cmd.emit_digit = 1'b1;
            if (status.last_digit) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
